>>> rtl/ial_pkg.sv
package ial_pkg;

    localparam int WORD_W    = 32;
    localparam int MODE_W    = 5;
    localparam int DIV_STEPS = 32;
    localparam int MUL_DEPTH = 3;
    localparam int LATENCY   = DIV_STEPS + 2;

    localparam logic [MODE_W-1:0] OP_ADD    = 5'd0;
    localparam logic [MODE_W-1:0] OP_SUB    = 5'd1;
    localparam logic [MODE_W-1:0] OP_AND    = 5'd2;
    localparam logic [MODE_W-1:0] OP_OR     = 5'd3;
    localparam logic [MODE_W-1:0] OP_XOR    = 5'd4;
    localparam logic [MODE_W-1:0] OP_SRL    = 5'd5;
    localparam logic [MODE_W-1:0] OP_SRA    = 5'd6;
    localparam logic [MODE_W-1:0] OP_SLL    = 5'd7;
    localparam logic [MODE_W-1:0] OP_MUL    = 5'd8;
    localparam logic [MODE_W-1:0] OP_MULH   = 5'd9;
    localparam logic [MODE_W-1:0] OP_MULHSU = 5'd10;
    localparam logic [MODE_W-1:0] OP_MULHU  = 5'd11;
    localparam logic [MODE_W-1:0] OP_DIV    = 5'd12;
    localparam logic [MODE_W-1:0] OP_DIVU   = 5'd13;
    localparam logic [MODE_W-1:0] OP_REM    = 5'd14;
    localparam logic [MODE_W-1:0] OP_REMU   = 5'd15;
    localparam logic [MODE_W-1:0] OP_EQ     = 5'd16;
    localparam logic [MODE_W-1:0] OP_NE     = 5'd17;
    localparam logic [MODE_W-1:0] OP_LT     = 5'd18;
    localparam logic [MODE_W-1:0] OP_GE     = 5'd19;
    localparam logic [MODE_W-1:0] OP_LTU    = 5'd20;
    localparam logic [MODE_W-1:0] OP_GEU    = 5'd21;

    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] op;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dsr;
        logic              neg_q;
        logic              neg_r;
        logic              dz;
    } stage_t;

endpackage

>>> rtl/ial_div_step.sv
module ial_div_step
    import ial_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t stage_in,
    output stage_t stage_out
);

    stage_t           stage_reg;
    stage_t           stage_next;
    logic [WORD_W:0]  trial;
    logic [WORD_W+1:0] diff;

    always_comb
    begin
        stage_next = stage_in;
        trial      = {stage_in.rem, stage_in.quo[WORD_W-1]};
        diff       = {1'b0, trial} - {2'b00, stage_in.dsr};
        if (!diff[WORD_W+1])
        begin
            stage_next.rem = diff[WORD_W-1:0];
            stage_next.quo = {stage_in.quo[WORD_W-2:0], 1'b1};
        end
        else
        begin
            stage_next.rem = trial[WORD_W-1:0];
            stage_next.quo = {stage_in.quo[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> rtl/ial_mul.sv
module ial_mul
    import ial_pkg::*;
(
    input  logic              clk,
    input  logic [MODE_W-1:0] op,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] product
);

    localparam int HALF = WORD_W / 2;

    logic [WORD_W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [WORD_W-1:0]   corr1_reg, corr2_reg;
    logic                low1_reg, low2_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0]   product_reg;
    logic [WORD_W-1:0]   corr_next;
    logic [2*WORD_W-1:0] prod_next;

    always_comb
    begin
        corr_next = '0;
        if (op == OP_MULH)
        begin
            corr_next = (a[WORD_W-1] ? b : '0) + (b[WORD_W-1] ? a : '0);
        end
        else if (op == OP_MULHSU)
        begin
            corr_next = a[WORD_W-1] ? b : '0;
        end
        prod_next = {hh_reg, ll_reg}
                  + {{HALF{1'b0}}, lh_reg, {HALF{1'b0}}}
                  + {{HALF{1'b0}}, hl_reg, {HALF{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        ll_reg      <= a[HALF-1:0] * b[HALF-1:0];
        lh_reg      <= a[HALF-1:0] * b[WORD_W-1:HALF];
        hl_reg      <= a[WORD_W-1:HALF] * b[HALF-1:0];
        hh_reg      <= a[WORD_W-1:HALF] * b[WORD_W-1:HALF];
        corr1_reg   <= corr_next;
        low1_reg    <= (op == OP_MUL);
        prod_reg    <= prod_next;
        corr2_reg   <= corr1_reg;
        low2_reg    <= low1_reg;
        product_reg <= low2_reg ? prod_reg[WORD_W-1:0]
                                : prod_reg[2*WORD_W-1:WORD_W] - corr2_reg;
    end

    assign product = product_reg;

endmodule

>>> rtl/rv32im_integer_alu_top.sv
// Every operation passes the same registers from the accepting edge to the done strobe.
// Throughput: one item per cycle; busy stays low, so start may be held every cycle.
// The 32-step restoring divider sets the depth; all operations share its pipeline.
// Reset clears the stages and done asynchronously; mul and result registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
module rv32im_integer_alu_top
    import ial_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [WORD_W-1:0] lhs_value,
    input  logic [WORD_W-1:0] rhs_value,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    stage_t            st [0:DIV_STEPS];
    stage_t            st_in [1:DIV_STEPS];
    stage_t            s0_next;
    stage_t            s0_reg;
    logic [WORD_W-1:0] mul_res;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;
    logic              done_reg;
    logic [4:0]        sh;
    logic              slt;
    logic              sgn_a;
    logic              sgn_b;
    logic              is_div;
    logic              is_mul;

    assign busy = 1'b0;

    always_comb
    begin
        sh    = rhs_value[4:0];
        slt   = $signed(lhs_value) < $signed(rhs_value);
        sgn_a = lhs_value[WORD_W-1];
        sgn_b = rhs_value[WORD_W-1];
        s0_next.valid = start;
        s0_next.op    = mode;
        s0_next.rem   = '0;
        s0_next.quo   = lhs_value;
        s0_next.dsr   = rhs_value;
        s0_next.neg_q = 1'b0;
        s0_next.neg_r = 1'b0;
        s0_next.dz    = (rhs_value == '0);
        case (mode)
            OP_ADD:  s0_next.res = lhs_value + rhs_value;
            OP_SUB:  s0_next.res = lhs_value - rhs_value;
            OP_AND:  s0_next.res = lhs_value & rhs_value;
            OP_OR:   s0_next.res = lhs_value | rhs_value;
            OP_XOR:  s0_next.res = lhs_value ^ rhs_value;
            OP_SRL:  s0_next.res = lhs_value >> sh;
            OP_SRA:  s0_next.res = WORD_W'($signed(lhs_value) >>> sh);
            OP_SLL:  s0_next.res = lhs_value << sh;
            OP_EQ:   s0_next.res = {{(WORD_W-1){1'b0}}, lhs_value == rhs_value};
            OP_NE:   s0_next.res = {{(WORD_W-1){1'b0}}, lhs_value != rhs_value};
            OP_LT:   s0_next.res = {{(WORD_W-1){1'b0}}, slt};
            OP_GE:   s0_next.res = {{(WORD_W-1){1'b0}}, !slt};
            OP_LTU:  s0_next.res = {{(WORD_W-1){1'b0}}, lhs_value < rhs_value};
            OP_GEU:  s0_next.res = {{(WORD_W-1){1'b0}}, !(lhs_value < rhs_value)};
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
            OP_DIV, OP_DIVU, OP_REM, OP_REMU:
                     s0_next.res = lhs_value;
            default: s0_next.res = '0;
        endcase
        if (mode == OP_DIV || mode == OP_REM)
        begin
            s0_next.quo   = sgn_a ? (~lhs_value + 1'b1) : lhs_value;
            s0_next.dsr   = sgn_b ? (~rhs_value + 1'b1) : rhs_value;
            s0_next.neg_q = (mode == OP_DIV) && (sgn_a ^ sgn_b);
            s0_next.neg_r = (mode == OP_REM) && sgn_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s0_reg   <= s0_next;
            done_reg <= st[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign st[0] = s0_reg;

    ial_mul u_mul
    (
        .clk     (clk),
        .op      (s0_reg.op),
        .a       (s0_reg.res),
        .b       (s0_reg.dsr),
        .product (mul_res)
    );

    assign is_mul = (st[MUL_DEPTH].op == OP_MUL) || (st[MUL_DEPTH].op == OP_MULH)
                 || (st[MUL_DEPTH].op == OP_MULHSU) || (st[MUL_DEPTH].op == OP_MULHU);

    genvar k;
    generate
        for (k = 1; k <= DIV_STEPS; k++)
        begin : g_div
            if (k == MUL_DEPTH + 1)
            begin : g_merge
                always_comb
                begin
                    st_in[k] = st[k-1];
                    if (is_mul)
                    begin
                        st_in[k].res = mul_res;
                    end
                end
            end
            else
            begin : g_pass
                assign st_in[k] = st[k-1];
            end
            ial_div_step u_step
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .stage_in  (st_in[k]),
                .stage_out (st[k])
            );
        end
    endgenerate

    always_comb
    begin
        is_div = 1'b0;
        case (st[DIV_STEPS].op)
            OP_DIV, OP_DIVU:
            begin
                is_div = 1'b1;
                if (st[DIV_STEPS].dz)
                    result_next = '1;
                else if (st[DIV_STEPS].neg_q)
                    result_next = ~st[DIV_STEPS].quo + 1'b1;
                else
                    result_next = st[DIV_STEPS].quo;
            end
            OP_REM, OP_REMU:
            begin
                is_div = 1'b1;
                if (st[DIV_STEPS].dz)
                    result_next = st[DIV_STEPS].res;
                else if (st[DIV_STEPS].neg_r)
                    result_next = ~st[DIV_STEPS].rem + 1'b1;
                else
                    result_next = st[DIV_STEPS].rem;
            end
            default: result_next = st[DIV_STEPS].res;
        endcase
        if (!is_div && !st[DIV_STEPS].valid)
            result_next = st[DIV_STEPS].res;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/ial_checker.sv
module ial_checker
    import ial_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [MODE_W-1:0] mode,
    input logic [WORD_W-1:0] lhs_value,
    input logic [WORD_W-1:0] rhs_value,
    input logic              done,
    input logic [WORD_W-1:0] result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without item");

    a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(mode, LATENCY) == OP_EQ || $past(mode, LATENCY) == OP_LTU)
        |-> result[WORD_W-1:1] == '0)
        else $error("compare not boolean");

    a_divu_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(mode, LATENCY) == OP_DIVU && $past(rhs_value, LATENCY) == '0
        |-> result == '1)
        else $error("divide by zero result");

    a_remu_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(mode, LATENCY) == OP_REMU && $past(rhs_value, LATENCY) == '0
        |-> result == $past(lhs_value, LATENCY))
        else $error("remainder by zero result");

endmodule

bind rv32im_integer_alu_top ial_checker u_ial_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .lhs_value (lhs_value),
    .rhs_value (rhs_value),
    .done      (done),
    .result    (result)
);
